FILE: src/kcd_pkg.sv
// Package for the KISS command deframer: field widths, KISS byte codes,
// result event codes, configuration register indexes and channel payload types.
// No dependencies.
`default_nettype none

package kcd_pkg;

    // Default size of the frame store, in stored bytes
    localparam int MAX_FRAME_DEF = 256;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 4;
    localparam int PLEN_W  = 9;
    localparam int COUNT_W = 32;
    localparam int MAXLEN_W = 9;
    localparam int HDR_W    = 7;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 1'd1;

    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST   = 9'd256;
    localparam logic [HDR_W-1:0]    HEADER_BYTES_RST = 7'd16;

    // KISS special bytes
    localparam logic [BYTE_W-1:0] KISS_FEND      = 8'hC0;
    localparam logic [BYTE_W-1:0] KISS_FESC      = 8'hDB;
    localparam logic [BYTE_W-1:0] KISS_TFEND     = 8'hDC;
    localparam logic [BYTE_W-1:0] KISS_TFESC     = 8'hDD;
    localparam logic [BYTE_W-1:0] KISS_DATA_TYPE = 8'h00;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_CONSUMED   = 4'd0;
    localparam logic [EVENT_W-1:0] EV_PAYLOAD    = 4'd1;
    localparam logic [EVENT_W-1:0] EV_COMPLETE   = 4'd2;
    localparam logic [EVENT_W-1:0] EV_EXTRA_FEND = 4'd3;
    localparam logic [EVENT_W-1:0] EV_NOT_DATA   = 4'd4;
    localparam logic [EVENT_W-1:0] EV_BAD_ESCAPE = 4'd5;
    localparam logic [EVENT_W-1:0] EV_OVERFLOW   = 4'd6;
    localparam logic [EVENT_W-1:0] EV_TOO_SHORT  = 4'd7;
    localparam logic [EVENT_W-1:0] EV_OUTSIDE    = 4'd8;

endpackage

`default_nettype wire

FILE: src/kcd_in_if.sv
// Input channel of the KISS command deframer: one received byte per transfer.
// Depends on kcd_pkg for the field width.
`default_nettype none

interface kcd_in_if;
    logic                        valid;
    logic                        ready;
    logic [kcd_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: src/kcd_out_if.sv
// Result channel of the KISS command deframer: one result per transfer.
// Depends on kcd_pkg for the field widths.
`default_nettype none

interface kcd_out_if;
    logic                          valid;
    logic                          ready;
    logic [kcd_pkg::EVENT_W-1:0]   event_res;
    logic [kcd_pkg::BYTE_W-1:0]    payload_byte;
    logic                          last;
    logic [kcd_pkg::PLEN_W-1:0]    payload_length;
    logic [kcd_pkg::COUNT_W-1:0]   command_count;

    modport source (output valid, output event_res, output payload_byte, output last,
                    output payload_length, output command_count, input ready);
    modport sink   (input valid, input event_res, input payload_byte, input last,
                    input payload_length, input command_count, output ready);
endinterface

`default_nettype wire

FILE: src/kiss_command_deframer.sv
// KISS command deframer top level: frame state, escape handling, header strip,
// result register and configuration registers.
// Depends on kcd_pkg, kcd_in_if and kcd_out_if.
//
//  channel   direction  transfer moves
//  i_in      in         rx_byte (one raw serial byte)
//  o_out     out        event_res, payload_byte, last, payload_length, command_count
//  cfg       in         i_cfg_we / i_cfg_idx / i_cfg_data, one register write per edge
//
//  A byte is taken every cycle unless o_out stalls; its result shows the cycle after.
//  The single result register sets the rate: a byte is taken whenever that
//  register is empty or its result is taken in the same cycle.
//  A stall on o_out holds the result and stops i_in until the transfer completes.
//  Synchronous active-low reset clears frame state, the command count and
//  loads max_length 256 and header_bytes 16.
`default_nettype none

module kiss_command_deframer #(
    parameter int MAX_FRAME = kcd_pkg::MAX_FRAME_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    kcd_in_if.sink                               i_in,
    kcd_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [kcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [kcd_pkg::CFG_W-1:0]       i_cfg_data
);

    // The stored count never exceeds max_length or MAX_FRAME, so it is capped at 511
    localparam int LIM_MAX = (MAX_FRAME < 511) ? MAX_FRAME : 511;
    localparam int CW      = $clog2(LIM_MAX + 1);
    localparam logic [kcd_pkg::MAXLEN_W-1:0] FRAME_CAP = kcd_pkg::MAXLEN_W'(LIM_MAX);

    // configuration
    logic [kcd_pkg::MAXLEN_W-1:0] r_max_length;
    logic [kcd_pkg::HDR_W-1:0]    r_header_bytes;

    // frame state
    logic                 r_in_frame, n_in_frame;
    logic                 r_expect_type, n_expect_type;
    logic                 r_escape, n_escape;
    logic [CW-1:0]        r_stored, n_stored;
    logic [kcd_pkg::COUNT_W-1:0] r_cmd_cnt, n_cmd_cnt;

    // result register
    logic                          r_valid;
    logic [kcd_pkg::EVENT_W-1:0]   r_event, n_event;
    logic [kcd_pkg::BYTE_W-1:0]    r_pay, n_pay;
    logic                          r_last, n_last;
    logic [kcd_pkg::PLEN_W-1:0]    r_plen, n_plen;

    logic                          w_accept;
    logic [kcd_pkg::BYTE_W-1:0]    w_b;
    logic [kcd_pkg::MAXLEN_W-1:0]  w_lim9;
    logic [CW-1:0]                 w_lim;
    logic                          w_full;
    logic                          w_past_hdr;
    logic                          w_long_enough;
    logic [kcd_pkg::BYTE_W-1:0]    w_store_val;
    logic                          w_do_store;

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_b        = i_in.rx_byte;

    assign w_lim9 = (r_max_length < FRAME_CAP) ? r_max_length : FRAME_CAP;
    assign w_lim  = w_lim9[CW-1:0];
    assign w_full = (r_stored >= w_lim);
    assign w_past_hdr    = (10'(r_stored) >= 10'(r_header_bytes));
    assign w_long_enough = (10'(r_stored) > (10'(r_header_bytes) + 10'd1));

    always_comb begin
        n_in_frame    = r_in_frame;
        n_expect_type = r_expect_type;
        n_escape      = r_escape;
        n_stored      = r_stored;
        n_cmd_cnt     = r_cmd_cnt;
        n_event       = kcd_pkg::EV_CONSUMED;
        n_pay         = '0;
        n_last        = 1'b0;
        n_plen        = '0;
        w_store_val   = w_b;
        w_do_store    = 1'b0;

        if (!r_in_frame) begin
            if (w_b == kcd_pkg::KISS_FEND) begin
                n_in_frame    = 1'b1;
                n_expect_type = 1'b1;
                n_escape      = 1'b0;
                n_stored      = '0;
            end else begin
                n_event = kcd_pkg::EV_OUTSIDE;
            end
        end else if (r_expect_type) begin
            if (w_b == kcd_pkg::KISS_FEND) begin
                n_event = kcd_pkg::EV_EXTRA_FEND;
            end else begin
                n_expect_type = 1'b0;
                if (w_b != kcd_pkg::KISS_DATA_TYPE) begin
                    n_event = kcd_pkg::EV_NOT_DATA;
                end
            end
        end else if (r_escape) begin
            n_escape = 1'b0;
            // a full frame reports overflow before the escape is checked
            if (w_full) begin
                n_event = kcd_pkg::EV_OVERFLOW;
            end else if (w_b == kcd_pkg::KISS_TFEND) begin
                w_store_val = kcd_pkg::KISS_FEND;
                w_do_store  = 1'b1;
            end else if (w_b == kcd_pkg::KISS_TFESC) begin
                w_store_val = kcd_pkg::KISS_FESC;
                w_do_store  = 1'b1;
            end else begin
                n_event = kcd_pkg::EV_BAD_ESCAPE;
            end
        end else if (w_b == kcd_pkg::KISS_FESC) begin
            n_escape = 1'b1;
        end else if (w_b == kcd_pkg::KISS_FEND) begin
            if (w_long_enough) begin
                n_cmd_cnt  = r_cmd_cnt + 32'd1;
                n_in_frame = 1'b0;
                n_event    = kcd_pkg::EV_COMPLETE;
                n_last     = 1'b1;
                n_plen     = kcd_pkg::PLEN_W'(10'(r_stored) - 10'(r_header_bytes));
            end else begin
                n_event = kcd_pkg::EV_TOO_SHORT;
            end
        end else begin
            w_do_store = 1'b1;
        end

        if (w_do_store) begin
            if (w_full) begin
                n_event = kcd_pkg::EV_OVERFLOW;
            end else begin
                n_stored = r_stored + CW'(1);
                if (w_past_hdr) begin
                    n_event = kcd_pkg::EV_PAYLOAD;
                    n_pay   = w_store_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length   <= kcd_pkg::MAX_LENGTH_RST;
            r_header_bytes <= kcd_pkg::HEADER_BYTES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kcd_pkg::REG_MAX_LENGTH: begin
                    r_max_length <= i_cfg_data[kcd_pkg::MAXLEN_W-1:0];
                end
                kcd_pkg::REG_HEADER_BYTES: begin
                    r_header_bytes <= i_cfg_data[kcd_pkg::HDR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_expect_type <= 1'b0;
            r_escape      <= 1'b0;
            r_stored      <= '0;
            r_cmd_cnt     <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_frame    <= n_in_frame;
                r_expect_type <= n_expect_type;
                r_escape      <= n_escape;
                r_stored      <= n_stored;
                r_cmd_cnt     <= n_cmd_cnt;
                r_valid       <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload of the result register, loaded on every accepted byte
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_event <= n_event;
            r_pay   <= n_pay;
            r_last  <= n_last;
            r_plen  <= n_plen;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.event_res      = r_event;
    assign o_out.payload_byte   = r_pay;
    assign o_out.last           = r_last;
    assign o_out.payload_length = r_plen;
    assign o_out.command_count  = r_cmd_cnt;

    a_last_is_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_event == kcd_pkg::EV_COMPLETE))
        else $error("last set on a result that is not a completion");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_event == kcd_pkg::EV_COMPLETE) |=>
            (r_cmd_cnt == $past(r_cmd_cnt) + 32'd1))
        else $error("command count did not advance on completion");

    a_type_no_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expect_type |-> (!r_escape && r_in_frame))
        else $error("escape pending or out of frame while waiting for type byte");

    a_pay_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_event != kcd_pkg::EV_PAYLOAD) |-> (r_pay == '0))
        else $error("payload byte nonzero on a non-payload result");

endmodule

`default_nettype wire

FILE: sim/kcd_result_checker.sv
// Result checker for the KISS command deframer: watches both channels and the
// register write port, predicts each result and compares it with the block output.
// Depends on kcd_pkg, kcd_in_if and kcd_out_if.
`timescale 1ns / 100ps
`default_nettype none

module kcd_result_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    kcd_in_if                                    i_in_mon,
    kcd_out_if                                   i_out_mon,
    input  wire logic                            i_cfg_we,
    input  wire logic [kcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [kcd_pkg::CFG_W-1:0]       i_cfg_data,
    output int                                   o_errors,
    output int                                   o_pending,
    output int                                   o_checked,
    output int                                   o_commands
);

    typedef struct {
        logic [kcd_pkg::EVENT_W-1:0] event_res;
        logic [kcd_pkg::BYTE_W-1:0]  payload_byte;
        logic                        last;
        logic [kcd_pkg::PLEN_W-1:0]  payload_length;
        logic [kcd_pkg::COUNT_W-1:0] command_count;
    } t_deframe_result;

    localparam int REPORT_MAX = 20;

    // Register copies
    int max_len;
    int hdr_len;

    // Deframer state
    logic                        in_frame;
    logic                        want_type;
    logic                        esc_pending;
    int                          stored;
    logic [kcd_pkg::COUNT_W-1:0] commands;

    t_deframe_result decoded_q[$];
    t_deframe_result want;
    t_deframe_result got;

    function automatic int store_limit();
        return (max_len < kcd_pkg::MAX_FRAME_DEF) ? max_len : kcd_pkg::MAX_FRAME_DEF;
    endfunction

    function automatic void keep_byte(input logic [kcd_pkg::BYTE_W-1:0] b,
                                      inout t_deframe_result r);
        if (stored >= store_limit()) begin
            r.event_res = kcd_pkg::EV_OVERFLOW;
        end else begin
            // bytes below the header size are stored but not streamed
            if (stored >= hdr_len) begin
                r.event_res    = kcd_pkg::EV_PAYLOAD;
                r.payload_byte = b;
            end
            stored++;
        end
    endfunction

    function automatic t_deframe_result deframe_byte(input logic [kcd_pkg::BYTE_W-1:0] b);
        t_deframe_result r;
        r.event_res      = kcd_pkg::EV_CONSUMED;
        r.payload_byte   = '0;
        r.last           = 1'b0;
        r.payload_length = '0;
        r.command_count  = '0;
        if (!in_frame) begin
            if (b == kcd_pkg::KISS_FEND) begin
                in_frame    = 1'b1;
                want_type   = 1'b1;
                esc_pending = 1'b0;
                stored      = 0;
            end else begin
                r.event_res = kcd_pkg::EV_OUTSIDE;
            end
        end else if (want_type) begin
            if (b == kcd_pkg::KISS_FEND) begin
                r.event_res = kcd_pkg::EV_EXTRA_FEND;
            end else begin
                want_type = 1'b0;
                if (b != kcd_pkg::KISS_DATA_TYPE) r.event_res = kcd_pkg::EV_NOT_DATA;
            end
        end else if (esc_pending) begin
            esc_pending = 1'b0;
            // a full frame reports overflow even for an invalid escape
            if (stored >= store_limit()) r.event_res = kcd_pkg::EV_OVERFLOW;
            else if (b == kcd_pkg::KISS_TFEND) keep_byte(kcd_pkg::KISS_FEND, r);
            else if (b == kcd_pkg::KISS_TFESC) keep_byte(kcd_pkg::KISS_FESC, r);
            else r.event_res = kcd_pkg::EV_BAD_ESCAPE;
        end else if (b == kcd_pkg::KISS_FESC) begin
            esc_pending = 1'b1;
        end else if (b == kcd_pkg::KISS_FEND) begin
            if (stored > hdr_len + 1) begin
                commands           = commands + 1'b1;
                in_frame           = 1'b0;
                r.event_res        = kcd_pkg::EV_COMPLETE;
                r.last             = 1'b1;
                r.payload_length   = kcd_pkg::PLEN_W'(stored - hdr_len);
            end else begin
                r.event_res = kcd_pkg::EV_TOO_SHORT;
            end
        end else begin
            keep_byte(b, r);
        end
        r.command_count = commands;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_len     = int'(kcd_pkg::MAX_LENGTH_RST);
            hdr_len     = int'(kcd_pkg::HEADER_BYTES_RST);
            in_frame    = 1'b0;
            want_type   = 1'b0;
            esc_pending = 1'b0;
            stored      = 0;
            commands    = '0;
            decoded_q.delete();
            o_errors    = 0;
            o_checked   = 0;
        end else begin
            // pop before push: a result never leaves in the cycle its byte enters
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.event_res      = i_out_mon.event_res;
                got.payload_byte   = i_out_mon.payload_byte;
                got.last           = i_out_mon.last;
                got.payload_length = i_out_mon.payload_length;
                got.command_count  = i_out_mon.command_count;
                if (decoded_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= REPORT_MAX)
                        $display("%0t: unexpected result: ev=%0d pay=%02h last=%0d %s",
                                 $time, got.event_res, got.payload_byte, got.last,
                                 $sformatf("len=%0d cnt=%0d", got.payload_length,
                                           got.command_count));
                end else begin
                    want = decoded_q.pop_front();
                    o_checked++;
                    if (got.event_res !== want.event_res ||
                        got.payload_byte !== want.payload_byte ||
                        got.last !== want.last ||
                        got.payload_length !== want.payload_length ||
                        got.command_count !== want.command_count) begin
                        o_errors++;
                        if (o_errors <= REPORT_MAX) begin
                            $display("%0t: mismatch, expected ev=%0d pay=%02h last=%0d %s",
                                     $time, want.event_res, want.payload_byte, want.last,
                                     $sformatf("len=%0d cnt=%0d", want.payload_length,
                                               want.command_count));
                            $display("%0t:           actual ev=%0d pay=%02h last=%0d %s",
                                     $time, got.event_res, got.payload_byte, got.last,
                                     $sformatf("len=%0d cnt=%0d", got.payload_length,
                                               got.command_count));
                        end
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                decoded_q.push_back(deframe_byte(i_in_mon.rx_byte));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kcd_pkg::REG_MAX_LENGTH:
                        max_len = int'(i_cfg_data[kcd_pkg::MAXLEN_W-1:0]);
                    kcd_pkg::REG_HEADER_BYTES:
                        hdr_len = int'(i_cfg_data[kcd_pkg::HDR_W-1:0]);
                    default: ;
                endcase
            end
        end
        o_pending  = decoded_q.size();
        o_commands = int'(commands);
    end

endmodule

`default_nettype wire

FILE: sim/kiss_command_deframer_tb.sv
// Testbench top for the KISS command deframer: clock, reset, byte stimulus,
// register writes, random stalls on the result channel and the verdict.
// Depends on kcd_pkg, kcd_in_if, kcd_out_if, kiss_command_deframer and kcd_result_checker.
`timescale 1ns / 100ps
`default_nettype none

module kiss_command_deframer_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASE_ITEMS  = 55;
    localparam int N_PRESET     = 9;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [kcd_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [kcd_pkg::CFG_W-1:0]     cfg_data;

    int errors;
    int pending;
    int checked;
    int commands;
    int cycles;
    int n_sent;
    int n_settings;
    int cur_max;
    int cur_hdr;
    logic send_calm;

    kcd_in_if  in_ch ();
    kcd_out_if out_ch ();

    kiss_command_deframer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    kcd_result_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_commands (commands)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: short and long stalls, with calm stretches of no stall
    initial begin
        int stall_left;
        int calm_left;
        int pick;
        stall_left   = 0;
        calm_left    = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3) calm_left = $urandom_range(50, 200);
                    else if (pick < 6) stall_left = $urandom_range(10, 40);
                    else if (pick < 30) stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so back-to-back bytes need no second assignment.
    task automatic send_byte(input logic [kcd_pkg::BYTE_W-1:0] b);
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic push_byte(input logic [kcd_pkg::BYTE_W-1:0] b);
        int pick;
        int gap;
        send_byte(b);
        pick = $urandom_range(0, 999);
        if (pick < 5) send_calm = ~send_calm;
        gap = 0;
        if (!send_calm) begin
            pick = $urandom_range(0, 99);
            if (pick >= 97) gap = $urandom_range(10, 30);
            else if (pick >= 65) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Hold the sender until every predicted result has been taken
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input int max_len, input int hdr_len);
        cfg_we   <= 1'b1;
        cfg_idx  <= kcd_pkg::REG_MAX_LENGTH;
        cfg_data <= kcd_pkg::CFG_W'(max_len);
        @(negedge i_clk);
        cfg_idx  <= kcd_pkg::REG_HEADER_BYTES;
        cfg_data <= kcd_pkg::CFG_W'(hdr_len);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
        cur_max = max_len;
        cur_hdr = hdr_len;
        n_settings++;
    endtask

    function automatic logic [kcd_pkg::BYTE_W-1:0] plain_byte();
        logic [kcd_pkg::BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == kcd_pkg::KISS_FEND || b == kcd_pkg::KISS_FESC)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Mostly well-formed frames with random content, some noise and broken frames
    task automatic send_frame();
        int pick;
        int lim;
        int body;
        logic [kcd_pkg::BYTE_W-1:0] b;
        lim  = (cur_max < kcd_pkg::MAX_FRAME_DEF) ? cur_max : kcd_pkg::MAX_FRAME_DEF;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            return;
        end
        push_byte(kcd_pkg::KISS_FEND);
        if ($urandom_range(0, 9) == 0) push_byte(kcd_pkg::KISS_FEND);
        if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(1, 255)));
        else push_byte(kcd_pkg::KISS_DATA_TYPE);
        pick = $urandom_range(0, 99);
        if (pick < 85 && pick >= 70) body = $urandom_range(0, cur_hdr + 1);
        else if (pick >= 85 && lim <= 40) body = lim + $urandom_range(1, 4);
        else body = cur_hdr + 2 + $urandom_range(0, 6);
        for (int i = 0; i < body; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                push_byte(kcd_pkg::KISS_FESC);
                push_byte(kcd_pkg::KISS_TFEND);
            end else if (pick < 16) begin
                push_byte(kcd_pkg::KISS_FESC);
                push_byte(kcd_pkg::KISS_TFESC);
            end else if (pick < 19) begin
                b = 8'($urandom_range(0, 255));
                while (b == kcd_pkg::KISS_TFEND || b == kcd_pkg::KISS_TFESC)
                    b = 8'($urandom_range(0, 255));
                push_byte(kcd_pkg::KISS_FESC);
                push_byte(b);
            end else if (pick < 21) begin
                push_byte(kcd_pkg::KISS_FEND);
            end else begin
                push_byte(plain_byte());
            end
        end
        push_byte(kcd_pkg::KISS_FEND);
    endtask

    initial begin
        int preset_max [N_PRESET];
        int preset_hdr [N_PRESET];
        int n_directed;
        int phase;
        int phase_start;
        preset_max = '{256, 1, 0, 256, 20, 40, 400, 8, 256};
        preset_hdr = '{0, 0, 0, 64, 3, 64, 2, 5, 16};
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        cfg_we        = 1'b0;
        cfg_idx       = kcd_pkg::REG_MAX_LENGTH;
        cfg_data      = '0;
        send_calm     = 1'b0;
        cur_max       = int'(kcd_pkg::MAX_LENGTH_RST);
        cur_hdr       = int'(kcd_pkg::HEADER_BYTES_RST);
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: two-byte store, no header, so every case shows in a few bytes
        write_cfg(2, 0);
        push_byte(8'h00);                   // outside a frame
        push_byte(8'hFF);
        push_byte(kcd_pkg::KISS_FEND);      // open
        push_byte(kcd_pkg::KISS_FEND);      // repeated before type
        push_byte(8'h55);                   // type other than data
        push_byte(kcd_pkg::KISS_FEND);      // too short, frame stays open
        push_byte(kcd_pkg::KISS_FESC);
        push_byte(kcd_pkg::KISS_TFEND);
        push_byte(kcd_pkg::KISS_FESC);
        push_byte(8'h12);                   // invalid escape
        push_byte(kcd_pkg::KISS_FEND);      // still too short
        push_byte(kcd_pkg::KISS_FESC);
        push_byte(kcd_pkg::KISS_TFESC);
        push_byte(8'h77);                   // store full
        push_byte(kcd_pkg::KISS_FESC);
        push_byte(8'h34);                   // escape into a full store
        push_byte(kcd_pkg::KISS_FEND);      // complete
        push_byte(kcd_pkg::KISS_FEND);
        push_byte(kcd_pkg::KISS_DATA_TYPE);
        push_byte(8'hFF);
        push_byte(8'hAA);
        push_byte(8'h01);
        push_byte(kcd_pkg::KISS_FEND);
        drain();
        n_directed = n_sent;

        phase = 0;
        while (n_sent - n_directed < RANDOM_ITEMS) begin
            if (phase < N_PRESET) write_cfg(preset_max[phase], preset_hdr[phase]);
            else write_cfg($urandom_range(1, 256), $urandom_range(0, 64));
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_ITEMS &&
                   n_sent - n_directed < RANDOM_ITEMS) begin
                send_frame();
                if ($urandom_range(0, 19) == 0) drain();
            end
            drain();
            phase++;
        end

        drain();
        $display("Sent %0d bytes over %0d register settings with random stalls on both sides;",
                 n_sent, n_settings);
        $display("checked %0d results, %0d commands completed.", checked, commands);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
